### rtl/radj_pkg.sv
// Shared widths, constants and types of the radar measurement Jacobian block.
package radj_pkg;

  // Width of every fixed-point field and of each saturated quotient.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QUO_W  = DATA_W;

  // The integer square root takes one result bit per stage.
  localparam int unsigned SQRT_STEPS = DATA_W;

  // Configuration register.
  localparam int unsigned        CFG_W         = 16;
  localparam logic [CFG_W-1:0]   MIN_RSQ_RESET = 16'd7;

  // Saturation limits: largest positive value and largest negative magnitude.
  localparam logic [DATA_W-1:0] FIX_MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] FIX_MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] fix_t;

endpackage

### rtl/radj_cfg_if.sv
// Write channel of the squared range threshold register.
interface radj_cfg_if import radj_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/radj_state_if.sv
// Input channel carrying one constant-velocity state.
interface radj_state_if import radj_pkg::*;
();
  logic valid;
  logic ready;
  fix_t pos_x;
  fix_t pos_y;
  fix_t vel_x;
  fix_t vel_y;

  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                  output ready);
endinterface

### rtl/radj_jac_if.sv
// Output channel carrying the distinct Jacobian entries and the proximity flag.
interface radj_jac_if import radj_pkg::*;
();
  logic valid;
  logic ready;
  fix_t range_dx;
  fix_t range_dy;
  fix_t bearing_dx;
  fix_t bearing_dy;
  fix_t rate_dx;
  fix_t rate_dy;
  logic too_close;

  modport source (output valid, output range_dx, output range_dy, output bearing_dx,
                  output bearing_dy, output rate_dx, output rate_dy, output too_close,
                  input ready);
  modport sink   (input valid, input range_dx, input range_dy, input bearing_dx,
                  input bearing_dy, input rate_dx, input rate_dy, input too_close,
                  output ready);
endinterface

### rtl/radar_jacobian_top.sv
// Top level of the radar measurement Jacobian pipeline.
// This block takes one state per cycle and returns one result per cycle while its output is
// not held. The integer square root resolves one result bit in each of its 32 stages, and
// the six dividers that run side by side after it each resolve one quotient bit per stage
// over 33 stages; the remaining stages register the input, form the squares and cross
// products, build the wide denominators and register the saturated output. The whole
// pipeline advances together, so when a result waits at the output the input stops taking
// states until that result is transferred. A state whose squared range lies below the
// threshold register shifted left by FRAC_BITS (or is zero) returns all-zero entries with
// too_close set. Quotients round toward zero and saturate at the 32-bit signed limits.
module radar_jacobian_top import radj_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  radj_cfg_if.sink      cfg_i,
  radj_state_if.sink    state_i,
  radj_jac_if.source    jac_o
);

  localparam int unsigned WIDE_W = 2 * DATA_W;
  localparam int unsigned PROD_W = 3 * DATA_W;
  localparam int unsigned NR_W   = DATA_W + FRAC_BITS;
  localparam int unsigned NB_W   = DATA_W + 2 * FRAC_BITS;
  localparam int unsigned NT_W   = PROD_W + FRAC_BITS;

  typedef struct packed {
    logic px_neg;
    logic py_neg;
    logic py_pos;
  } sign_t;

  typedef struct packed {
    logic [DATA_W-1:0] apx;
    logic [DATA_W-1:0] apy;
    logic [WIDE_W-1:0] d;
    logic [WIDE_W-1:0] cmag;
    sign_t             sgn;
    logic              cneg;
    logic              close;
  } sq_side_t;

  typedef struct packed {
    logic rx;
    logic ry;
    logic bx;
    logic by;
    logic tx;
    logic ty;
    logic close;
  } out_side_t;

  function automatic logic [DATA_W-1:0] sat_out(input logic neg, input logic [QUO_W-1:0] q,
                                                input logic ovf);
    logic [DATA_W-1:0] m;
    if (neg) begin
      m = (ovf || (q > FIX_MAX_NEG)) ? FIX_MAX_NEG : q;
      return DATA_W'(~m + 1'b1);
    end else begin
      m = (ovf || q[QUO_W-1]) ? FIX_MAX_POS : q;
      return m;
    end
  endfunction

  logic en;
  logic out_vld_q;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en            = !out_vld_q || jac_o.ready;
  assign state_i.ready = en;

  // Threshold register, always ready for a transfer.
  logic [CFG_W-1:0] min_rsq_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rsq_q <= MIN_RSQ_RESET;
    end else if (cfg_i.valid) begin
      min_rsq_q <= cfg_i.data;
    end
  end

  // Stage 0: register the state with position magnitudes and signs.
  logic              s0_vld_q;
  logic [DATA_W-1:0] s0_apx_q, s0_apy_q;
  fix_t              s0_px_q, s0_py_q, s0_vx_q, s0_vy_q;
  sign_t             s0_sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= state_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_apx_q <= state_i.pos_x[DATA_W-1] ? DATA_W'(-state_i.pos_x) : DATA_W'(state_i.pos_x);
      s0_apy_q <= state_i.pos_y[DATA_W-1] ? DATA_W'(-state_i.pos_y) : DATA_W'(state_i.pos_y);
      s0_px_q  <= state_i.pos_x;
      s0_py_q  <= state_i.pos_y;
      s0_vx_q  <= state_i.vel_x;
      s0_vy_q  <= state_i.vel_y;
      s0_sgn_q.px_neg <= state_i.pos_x[DATA_W-1];
      s0_sgn_q.py_neg <= state_i.pos_y[DATA_W-1];
      s0_sgn_q.py_pos <= !state_i.pos_y[DATA_W-1] && (state_i.pos_y != '0);
    end
  end

  // Stage 1: squares of the position and the two cross products.
  logic                     s1_vld_q;
  logic [WIDE_W-1:0]        s1_sqx_q, s1_sqy_q;
  logic signed [WIDE_W-1:0] s1_t1_q, s1_t2_q;
  logic [DATA_W-1:0]        s1_apx_q, s1_apy_q;
  sign_t                    s1_sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sqx_q <= s0_apx_q * s0_apx_q;
      s1_sqy_q <= s0_apy_q * s0_apy_q;
      s1_t1_q  <= s0_vx_q * s0_py_q;
      s1_t2_q  <= s0_vy_q * s0_px_q;
      s1_apx_q <= s0_apx_q;
      s1_apy_q <= s0_apy_q;
      s1_sgn_q <= s0_sgn_q;
    end
  end

  // Stage 2: squared range, proximity test and cross-product magnitude.
  // This stage is also the entry of the square root pipeline.
  logic [WIDE_W-1:0] sq_v_q    [0:SQRT_STEPS];
  logic [WIDE_W-1:0] sq_r_q    [0:SQRT_STEPS];
  sq_side_t          sq_side_q [0:SQRT_STEPS];
  logic              sq_vld_q  [0:SQRT_STEPS];

  logic [WIDE_W-1:0] d_c;
  logic              cneg_c;

  assign d_c    = s1_sqx_q + s1_sqy_q;
  assign cneg_c = s1_t1_q < s1_t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_v_q[0]          <= d_c;
      sq_r_q[0]          <= '0;
      sq_side_q[0].apx   <= s1_apx_q;
      sq_side_q[0].apy   <= s1_apy_q;
      sq_side_q[0].d     <= d_c;
      sq_side_q[0].cmag  <= cneg_c ? WIDE_W'(s1_t2_q - s1_t1_q) : WIDE_W'(s1_t1_q - s1_t2_q);
      sq_side_q[0].sgn   <= s1_sgn_q;
      sq_side_q[0].cneg  <= cneg_c;
      sq_side_q[0].close <= (d_c == '0) || (d_c < (WIDE_W'(min_rsq_q) << FRAC_BITS));
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [WIDE_W-1:0] SqBit = WIDE_W'(1) << (WIDE_W - 2 - 2 * k);

    logic [WIDE_W:0] trial;
    logic            fits;

    assign trial = {1'b0, sq_r_q[k]} + {1'b0, SqBit};
    assign fits  = {1'b0, sq_v_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_v_q[k+1]    <= fits ? (sq_v_q[k] - WIDE_W'(trial)) : sq_v_q[k];
        sq_r_q[k+1]    <= fits ? ((sq_r_q[k] >> 1) + SqBit) : (sq_r_q[k] >> 1);
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // Multiply stage: 64-bit partial products, from 32-bit slices, of the wide denominator and numerators.
  sq_side_t          sq_out;
  logic [DATA_W-1:0] root_c;

  assign sq_out = sq_side_q[SQRT_STEPS];
  assign root_c = sq_r_q[SQRT_STEPS][DATA_W-1:0];

  logic              m1_vld_q;
  logic [WIDE_W-1:0] m1_drl_q, m1_drh_q, m1_nxl_q, m1_nxh_q, m1_nyl_q, m1_nyh_q;
  logic [DATA_W-1:0] m1_r_q;
  sq_side_t          m1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= sq_vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_drl_q  <= sq_out.d[DATA_W-1:0] * root_c;
      m1_drh_q  <= sq_out.d[WIDE_W-1:DATA_W] * root_c;
      m1_nxl_q  <= sq_out.apx * sq_out.cmag[DATA_W-1:0];
      m1_nxh_q  <= sq_out.apx * sq_out.cmag[WIDE_W-1:DATA_W];
      m1_nyl_q  <= sq_out.apy * sq_out.cmag[DATA_W-1:0];
      m1_nyh_q  <= sq_out.apy * sq_out.cmag[WIDE_W-1:DATA_W];
      m1_r_q    <= root_c;
      m1_side_q <= sq_out;
    end
  end

  // Combine stage: full-width operands and the sign of each quotient.
  logic              m2_vld_q;
  logic [NR_W-1:0]   m2_nrx_q, m2_nry_q;
  logic [NB_W-1:0]   m2_nbx_q, m2_nby_q;
  logic [NT_W-1:0]   m2_ntx_q, m2_nty_q;
  logic [DATA_W-1:0] m2_r_q;
  logic [WIDE_W-1:0] m2_d_q;
  logic [PROD_W-1:0] m2_dr_q;
  out_side_t         m2_side_q;

  logic [PROD_W-1:0] nx_c, ny_c;
  logic              cnz_c;

  assign nx_c  = (PROD_W'(m1_nxh_q) << DATA_W) + PROD_W'(m1_nxl_q);
  assign ny_c  = (PROD_W'(m1_nyh_q) << DATA_W) + PROD_W'(m1_nyl_q);
  assign cnz_c = m1_side_q.cmag != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_nrx_q <= NR_W'(m1_side_q.apx) << FRAC_BITS;
      m2_nry_q <= NR_W'(m1_side_q.apy) << FRAC_BITS;
      m2_nbx_q <= NB_W'(m1_side_q.apy) << (2 * FRAC_BITS);
      m2_nby_q <= NB_W'(m1_side_q.apx) << (2 * FRAC_BITS);
      m2_ntx_q <= NT_W'(ny_c) << FRAC_BITS;
      m2_nty_q <= NT_W'(nx_c) << FRAC_BITS;
      m2_r_q   <= m1_r_q;
      m2_d_q   <= m1_side_q.d;
      m2_dr_q  <= (PROD_W'(m1_drh_q) << DATA_W) + PROD_W'(m1_drl_q);
      m2_side_q.rx    <= m1_side_q.sgn.px_neg;
      m2_side_q.ry    <= m1_side_q.sgn.py_neg;
      m2_side_q.bx    <= m1_side_q.sgn.py_pos;
      m2_side_q.by    <= m1_side_q.sgn.px_neg;
      m2_side_q.tx    <= (m1_side_q.sgn.py_neg != m1_side_q.cneg) && cnz_c;
      m2_side_q.ty    <= (m1_side_q.sgn.px_neg == m1_side_q.cneg) && cnz_c;
      m2_side_q.close <= m1_side_q.close;
    end
  end

  // Six dividers in parallel.
  logic [QUO_W-1:0] q_rx, q_ry, q_bx, q_by, q_tx, q_ty;
  logic             o_rx, o_ry, o_bx, o_by, o_tx, o_ty;

  radj_div #(.NUM_W(NR_W), .DEN_W(DATA_W)) u_div_rx (
    .clk_i(clk_i), .en_i(en), .num_i(m2_nrx_q), .den_i(m2_r_q), .quo_o(q_rx), .ovf_o(o_rx)
  );
  radj_div #(.NUM_W(NR_W), .DEN_W(DATA_W)) u_div_ry (
    .clk_i(clk_i), .en_i(en), .num_i(m2_nry_q), .den_i(m2_r_q), .quo_o(q_ry), .ovf_o(o_ry)
  );
  radj_div #(.NUM_W(NB_W), .DEN_W(WIDE_W)) u_div_bx (
    .clk_i(clk_i), .en_i(en), .num_i(m2_nbx_q), .den_i(m2_d_q), .quo_o(q_bx), .ovf_o(o_bx)
  );
  radj_div #(.NUM_W(NB_W), .DEN_W(WIDE_W)) u_div_by (
    .clk_i(clk_i), .en_i(en), .num_i(m2_nby_q), .den_i(m2_d_q), .quo_o(q_by), .ovf_o(o_by)
  );
  radj_div #(.NUM_W(NT_W), .DEN_W(PROD_W)) u_div_tx (
    .clk_i(clk_i), .en_i(en), .num_i(m2_ntx_q), .den_i(m2_dr_q), .quo_o(q_tx), .ovf_o(o_tx)
  );
  radj_div #(.NUM_W(NT_W), .DEN_W(PROD_W)) u_div_ty (
    .clk_i(clk_i), .en_i(en), .num_i(m2_nty_q), .den_i(m2_dr_q), .quo_o(q_ty), .ovf_o(o_ty)
  );

  // Signs and valid bits travel alongside the divider stages.
  out_side_t dl_side_q [0:QUO_W];
  logic      dl_vld_q  [0:QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q[0] <= 1'b0;
    end else if (en) begin
      dl_vld_q[0] <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_side_q[0] <= m2_side_q;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_delay
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        dl_vld_q[k+1] <= dl_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_side_q[k+1] <= dl_side_q[k];
      end
    end
  end

  // Output register: saturate, apply signs, zero everything when too close.
  out_side_t         fin;
  logic [DATA_W-1:0] out_rdx_q, out_rdy_q, out_bdx_q, out_bdy_q, out_tdx_q, out_tdy_q;
  logic              out_close_q;

  assign fin = dl_side_q[QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dl_vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rdx_q   <= fin.close ? '0 : sat_out(fin.rx, q_rx, o_rx);
      out_rdy_q   <= fin.close ? '0 : sat_out(fin.ry, q_ry, o_ry);
      out_bdx_q   <= fin.close ? '0 : sat_out(fin.bx, q_bx, o_bx);
      out_bdy_q   <= fin.close ? '0 : sat_out(fin.by, q_by, o_by);
      out_tdx_q   <= fin.close ? '0 : sat_out(fin.tx, q_tx, o_tx);
      out_tdy_q   <= fin.close ? '0 : sat_out(fin.ty, q_ty, o_ty);
      out_close_q <= fin.close;
    end
  end

  assign jac_o.valid      = out_vld_q;
  assign jac_o.range_dx   = out_rdx_q;
  assign jac_o.range_dy   = out_rdy_q;
  assign jac_o.bearing_dx = out_bdx_q;
  assign jac_o.bearing_dy = out_bdy_q;
  assign jac_o.rate_dx    = out_tdx_q;
  assign jac_o.rate_dy    = out_tdy_q;
  assign jac_o.too_close  = out_close_q;

endmodule

### rtl/radj_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module radj_div import radj_pkg::*; #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [DEN_W-1:0] rem_q [0:QUO_W];
  logic [DEN_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0] low_q [0:QUO_W];
  logic [QUO_W-1:0] quo_q [0:QUO_W];
  logic             ovf_q [0:QUO_W];

  // Entry stage: the upper numerator bits form the first partial remainder.
  // The quotient does not fit when those bits alone reach the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(num_i >> QUO_W);
      den_q[0] <= den_i;
      low_q[0] <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= CMP_W'(num_i >> QUO_W) >= CMP_W'(den_i);
    end
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem_q[j], low_q[j][QUO_W-1]};
    assign fits  = trial >= {1'b0, den_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= fits ? DEN_W'(trial - {1'b0, den_q[j]}) : DEN_W'(trial);
        den_q[j+1] <= den_q[j];
        low_q[j+1] <= {low_q[j][QUO_W-2:0], 1'b0};
        quo_q[j+1] <= {quo_q[j][QUO_W-2:0], fits};
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

### rtl/radj_checker.sv
// Port-level checker of the radar Jacobian block and its bind to the top level.
module radj_checker import radj_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] range_dx_i,
  input logic [DATA_W-1:0] range_dy_i,
  input logic [DATA_W-1:0] bearing_dx_i,
  input logic [DATA_W-1:0] bearing_dy_i,
  input logic [DATA_W-1:0] rate_dx_i,
  input logic [DATA_W-1:0] rate_dy_i,
  input logic              too_close_i
);

  localparam int signed OneFix = 1 << FRAC_BITS;

  // A stalled result stays valid, with range_dx, bearing_dx, rate_dy and too_close unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(range_dx_i) &&
    $stable(bearing_dx_i) && $stable(rate_dy_i) && $stable(too_close_i))
    else $error("stalled result changed");

  // The whole pipeline halts while a result waits, so no state is taken.
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("state taken while the output is stalled");

  // A state too near the origin gives all-zero entries.
  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && too_close_i |-> range_dx_i == '0 && range_dy_i == '0 &&
    bearing_dx_i == '0 && bearing_dy_i == '0 && rate_dx_i == '0 && rate_dy_i == '0)
    else $error("non-zero entry with too_close set");

  // Range derivatives are direction cosines and never exceed one in magnitude.
  a_range_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $signed(range_dx_i) <= OneFix && $signed(range_dx_i) >= -OneFix &&
    $signed(range_dy_i) <= OneFix && $signed(range_dy_i) >= -OneFix)
    else $error("range derivative beyond unit magnitude");

endmodule

bind radar_jacobian_top radj_checker #(.FRAC_BITS(FRAC_BITS)) u_radj_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (state_i.ready),
  .out_valid_i  (jac_o.valid),
  .out_ready_i  (jac_o.ready),
  .range_dx_i   (jac_o.range_dx),
  .range_dy_i   (jac_o.range_dy),
  .bearing_dx_i (jac_o.bearing_dx),
  .bearing_dy_i (jac_o.bearing_dy),
  .rate_dx_i    (jac_o.rate_dx),
  .rate_dy_i    (jac_o.rate_dy),
  .too_close_i  (jac_o.too_close)
);

### test/radar_jacobian_top_tb.sv
// Self-checking testbench of the radar measurement Jacobian pipeline.
module radar_jacobian_top_tb import radj_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC      = 16;
  localparam int unsigned LATENCY   = 70;
  localparam int unsigned STALL_MAX = 5000;
  localparam int unsigned HOLD_LEN  = 300;

  typedef struct packed {
    fix_t pos_x;
    fix_t pos_y;
    fix_t vel_x;
    fix_t vel_y;
  } track_state_t;

  typedef struct packed {
    fix_t range_dx;
    fix_t range_dy;
    fix_t bearing_dx;
    fix_t bearing_dy;
    fix_t rate_dx;
    fix_t rate_dy;
    logic too_close;
  } jacobian_t;

  logic clk_i;
  logic rst_ni;

  radj_cfg_if   cfg_bus ();
  radj_state_if state_bus ();
  radj_jac_if   jac_bus ();

  radar_jacobian_top #(.FRAC_BITS(FRAC)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .state_i (state_bus),
    .jac_o   (jac_bus)
  );

  track_state_t     pending_states[$];
  jacobian_t        expected_jacobians[$];
  logic [CFG_W-1:0] min_rsq;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  int unsigned      hold_left;
  bit               hold_request;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Truncated quotient with sign applied and saturated to 32 bits.
  function automatic fix_t sat_quotient(bit neg, logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] cap;
    q   = num / den;
    cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > cap) q = cap;
    return neg ? fix_t'(-q[31:0]) : fix_t'(q[31:0]);
  endfunction

  // Expected Jacobian entries of one state under the current threshold.
  function automatic jacobian_t jacobian_of(track_state_t s);
    jacobian_t          j;
    logic signed [63:0] px, py, vx, vy, t1, t2;
    logic [63:0]        apx, apy, d, r, cmag;
    logic [127:0]       dr;
    bit                 cneg;
    px  = s.pos_x;
    py  = s.pos_y;
    vx  = s.vel_x;
    vy  = s.vel_y;
    apx = px < 0 ? -px : px;
    apy = py < 0 ? -py : py;
    d   = apx * apx + apy * apy;
    j   = '0;
    if (d == 0 || d < ({48'd0, min_rsq} << FRAC)) begin
      j.too_close = 1'b1;
      return j;
    end
    r    = floor_sqrt(d);
    t1   = vx * py;
    t2   = vy * px;
    cneg = t1 < t2;
    cmag = cneg ? t2 - t1 : t1 - t2;
    dr   = {64'd0, d} * {64'd0, r};
    j.range_dx   = sat_quotient(px < 0, {64'd0, apx} << FRAC, {64'd0, r});
    j.range_dy   = sat_quotient(py < 0, {64'd0, apy} << FRAC, {64'd0, r});
    j.bearing_dx = sat_quotient(py > 0, {64'd0, apy} << (2 * FRAC), {64'd0, d});
    j.bearing_dy = sat_quotient(px < 0, {64'd0, apx} << (2 * FRAC), {64'd0, d});
    j.rate_dx    = sat_quotient(((py < 0) != cneg) && cmag != 0,
                                ({64'd0, apy} * {64'd0, cmag}) << FRAC, dr);
    j.rate_dy    = sat_quotient(((px < 0) == cneg) && cmag != 0,
                                ({64'd0, apx} * {64'd0, cmag}) << FRAC, dr);
    return j;
  endfunction

  // Random field value drawn from several magnitude classes.
  function automatic fix_t random_fix();
    case ($urandom_range(0, 5))
      0, 1:    return fix_t'($urandom);
      2:       return fix_t'($urandom_range(0, 32'h0004_0000)) - fix_t'(32'h0002_0000);
      3:       return fix_t'($urandom_range(0, 2048)) - fix_t'(1024);
      4:       return fix_t'($urandom_range(0, 32'h0200_0000)) - fix_t'(32'h0100_0000);
      default: begin
        case ($urandom_range(0, 4))
          0:       return fix_t'(FIX_MAX_POS);
          1:       return fix_t'(FIX_MAX_NEG);
          2:       return fix_t'(-1);
          3:       return fix_t'(1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, fix_t got, fix_t want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic queue_state(fix_t px, fix_t py, fix_t vx, fix_t vy);
    track_state_t s;
    s = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy};
    pending_states.push_back(s);
  endtask

  // Waits until every queued state has come back, then for the pipeline depth.
  task automatic drain_pipeline();
    wait (pending_states.size() == 0 && expected_jacobians.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Writes the threshold register over its own channel.
  task automatic write_threshold(logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    min_rsq = value;
    cfg_bus.valid <= 1'b0;
  endtask

  // State driver: offers the next pending state once the previous one is transferred.
  always @(posedge clk_i) begin
    if (rst_ni && (!state_bus.valid || state_bus.ready)) begin
      if (pending_states.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        track_state_t s;
        s = pending_states.pop_front();
        state_bus.pos_x <= s.pos_x;
        state_bus.pos_y <= s.pos_y;
        state_bus.vel_x <= s.vel_x;
        state_bus.vel_y <= s.vel_y;
        state_bus.valid <= 1'b1;
      end else begin
        state_bus.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predicts the result of each transferred state.
  always @(posedge clk_i) begin
    if (rst_ni && state_bus.valid && state_bus.ready) begin
      track_state_t s;
      s = '{pos_x: state_bus.pos_x, pos_y: state_bus.pos_y,
            vel_x: state_bus.vel_x, vel_y: state_bus.vel_y};
      expected_jacobians.push_back(jacobian_of(s));
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      jac_bus.ready <= 1'b0;
    end else begin
      jac_bus.ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Output monitor: compares each transferred result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && jac_bus.valid && jac_bus.ready) begin
      if (expected_jacobians.size() == 0) begin
        $display("result transferred with no prediction waiting");
        mismatches++;
      end else begin
        jacobian_t w;
        w = expected_jacobians.pop_front();
        if (jac_bus.range_dx !== w.range_dx)
          report_mismatch("range_dx", jac_bus.range_dx, w.range_dx);
        if (jac_bus.range_dy !== w.range_dy)
          report_mismatch("range_dy", jac_bus.range_dy, w.range_dy);
        if (jac_bus.bearing_dx !== w.bearing_dx)
          report_mismatch("bearing_dx", jac_bus.bearing_dx, w.bearing_dx);
        if (jac_bus.bearing_dy !== w.bearing_dy)
          report_mismatch("bearing_dy", jac_bus.bearing_dy, w.bearing_dy);
        if (jac_bus.rate_dx !== w.rate_dx)
          report_mismatch("rate_dx", jac_bus.rate_dx, w.rate_dx);
        if (jac_bus.rate_dy !== w.rate_dy)
          report_mismatch("rate_dy", jac_bus.rate_dy, w.rate_dy);
        if (jac_bus.too_close !== w.too_close)
          report_mismatch("too_close", fix_t'(jac_bus.too_close), fix_t'(w.too_close));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((state_bus.valid && state_bus.ready) || (jac_bus.valid && jac_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset, directed states, then random phases under several thresholds.
  initial begin
    logic [CFG_W-1:0] thresholds[4];
    rst_ni          = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = '0;
    state_bus.valid = 1'b0;
    state_bus.pos_x = '0;
    state_bus.pos_y = '0;
    state_bus.vel_x = '0;
    state_bus.vel_y = '0;
    jac_bus.ready   = 1'b0;
    min_rsq         = MIN_RSQ_RESET;
    send_idle_pct   = 20;
    recv_idle_pct   = 88;
    mismatches      = 0;
    quiet_cycles    = 0;
    hold_left       = 0;
    hold_request    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: origin, threshold edges, field extremes and saturating quotients.
    queue_state('0, '0, fix_t'(FIX_MAX_POS), fix_t'(FIX_MAX_NEG));
    queue_state(fix_t'(1), '0, '0, '0);
    queue_state(fix_t'(32'h0000_02A5), '0, fix_t'(32'h0001_0000), '0);
    queue_state(fix_t'(32'h0000_02A6), '0, '0, fix_t'(32'h0001_0000));
    queue_state(fix_t'(FIX_MAX_POS), fix_t'(FIX_MAX_POS), fix_t'(FIX_MAX_POS),
                fix_t'(FIX_MAX_NEG));
    queue_state(fix_t'(FIX_MAX_NEG), fix_t'(FIX_MAX_NEG), fix_t'(FIX_MAX_NEG),
                fix_t'(FIX_MAX_POS));
    queue_state(fix_t'(FIX_MAX_NEG), '0, '0, fix_t'(FIX_MAX_NEG));
    queue_state('0, fix_t'(FIX_MAX_NEG), fix_t'(FIX_MAX_NEG), '0);
    queue_state('0, fix_t'(32'h0000_0800), fix_t'(FIX_MAX_POS), '0);
    queue_state(fix_t'(32'h0000_0800), '0, '0, fix_t'(FIX_MAX_NEG));
    queue_state(fix_t'(-32'sh800), fix_t'(32'h0000_0800), fix_t'(FIX_MAX_POS),
                fix_t'(FIX_MAX_POS));
    queue_state(fix_t'(32'h0001_0000), fix_t'(32'h0001_0000), fix_t'(32'h0001_0000),
                fix_t'(32'h0001_0000));
    queue_state(fix_t'(32'h0003_0000), fix_t'(-32'sh4_0000), fix_t'(-32'sh2_0000),
                fix_t'(32'h0005_0000));
    queue_state(fix_t'(-1), fix_t'(-1), fix_t'(-1), fix_t'(-1));
    queue_state(fix_t'(32'h5555_5555), fix_t'(32'hAAAA_AAAA), fix_t'(32'h5555_5555),
                fix_t'(32'hAAAA_AAAA));
    drain_pipeline();

    // Random phases; the second holds the receiver off to fill the pipeline.
    thresholds = '{16'hFFFF, 16'd0, 16'(MIN_RSQ_RESET + 0), 16'd1};
    thresholds[2] = CFG_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thresholds[ph]);
      if (ph == 2) begin
        send_idle_pct = 88;
        recv_idle_pct = 20;
      end else if (ph == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 270; n++)
        queue_state(random_fix(), random_fix(), random_fix(), random_fix());
      if (ph == 1) begin
        repeat (20) @(posedge clk_i);
        hold_request = 1'b1;
      end
      drain_pipeline();
    end

    if (mismatches == 0 && expected_jacobians.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
